// ===== rtl/trme_pkg.sv =====
// Package for the register/memory executor: shared types, opcodes and constants.
// No dependencies.
package trme_pkg;
   localparam int MEM_WORDS_DEF = 256;
   localparam int LINE_BITS_DEF = 16;
   localparam int WORD_BITS = 64;
   localparam int NUM_REGS = 4;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_AND = 4'd2, OP_OR = 4'd3, OP_NOT = 4'd4,
      OP_MOV = 4'd5, OP_CMP = 4'd6, OP_JMP = 4'd7, OP_JE = 4'd8, OP_JNE = 4'd9,
      OP_JGE = 4'd10, OP_JL = 4'd11, OP_IN = 4'd12, OP_OUT = 4'd13, OP_NOP = 4'd14,
      OP_BAD = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      KIND_REG = 2'd0, KIND_MEM = 2'd1, KIND_IND = 2'd2, KIND_IMM = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0, ERR_OPERAND = 2'd1, ERR_RANGE = 2'd2, ERR_OP = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      FLAG_EQ = 2'b00, FLAG_GT = 2'b01, FLAG_LT = 2'b11
   } flag_type;

   typedef enum logic [1:0] {
      ST_CLEAR, ST_IDLE, ST_SECOND, ST_EXEC
   } back_state_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [1:0]  first_kind;
      logic [7:0]  first_index;
      logic [63:0] first_immediate;
      logic [1:0]  second_kind;
      logic [7:0]  second_index;
      logic [63:0] second_immediate;
      logic [15:0] jump_target;
      logic [63:0] console_value;
   } req_type;

   typedef struct packed {
      logic [15:0] next_line;
      logic [63:0] print_value;
      logic        print_valid;
      logic        jump_taken;
      logic [1:0]  compare_state;
      logic [1:0]  error_code;
   } rsp_type;
endpackage

// ===== rtl/trme_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on trme_pkg.
interface trme_req_if;
   logic               valid;
   logic               ready;
   trme_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface trme_rsp_if;
   logic               valid;
   logic               ready;
   trme_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/toy_register_memory_executor_unit.sv =====
// Top level of the register/memory executor.
// Depends on trme_pkg, trme_if, trme_front, trme_back and trme_ram.
//
// The req channel takes one decoded instruction per transfer and the rsp
// channel gives one result per instruction, in order. The front end holds
// up to two instructions in a queue, so requests can still be taken while
// the back end is busy or the receiver stalls, until the queue is full.
// For each instruction the back end reads the first operand from data
// memory, then the second, then executes and writes back. The single read
// port of the data memory is why the operands are read in turn. A result
// appears in the cycle after execution and holds in the output register
// while rsp.ready is low; the next instruction then waits in its execute
// step. After reset the back end clears the data memory, one word a cycle,
// before it takes the first instruction; requests are queued meanwhile.
// Reset zeroes the registers, compare flag and line counter.
module toy_register_memory_executor_unit #(
   parameter int MEM_WORDS = trme_pkg::MEM_WORDS_DEF,
   parameter int LINE_BITS = trme_pkg::LINE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   trme_req_if.sink   req,
   trme_rsp_if.source rsp
);
   logic              q_valid, q_pop;
   trme_pkg::req_type q_data;

   trme_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

   trme_back #(.MEM_WORDS(MEM_WORDS), .LINE_BITS(LINE_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data),
      .q_pop(q_pop), .rsp(rsp));
endmodule

// ===== rtl/trme_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module trme_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/trme_front.sv =====
// Front end: takes request transfers into a two-entry queue for the back end.
// Depends on trme_pkg and trme_if.
module trme_front (
   input  logic               clock,
   input  logic               reset,
   trme_req_if.sink           req,
   output logic               q_valid,
   output trme_pkg::req_type  q_data,
   input  logic               q_pop
);
   trme_pkg::req_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;

   assign req.ready = (count_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign q_valid = (count_ff != 2'd0);
   assign q_data = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in = rd_ff ^ q_pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= req.data;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0) else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count mismatch");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == 2'd0) else $error("queue not empty after reset");
`endif
endmodule

// ===== rtl/trme_back.sv =====
// Back end: clears data memory, reads operands one after the other, executes, writes back.
// Depends on trme_pkg and trme_ram.
module trme_back #(
   parameter int MEM_WORDS = trme_pkg::MEM_WORDS_DEF,
   parameter int LINE_BITS = trme_pkg::LINE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  trme_pkg::req_type  q_data,
   output logic               q_pop,
   trme_rsp_if.source         rsp
);
   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int RD = (MEM_WORDS > 1) ? MEM_WORDS : 2;

   trme_pkg::back_state_type st_ff, st_in;
   logic [AW:0] clr_ff, clr_in;
   logic [63:0] reg_ff [trme_pkg::NUM_REGS];
   logic [1:0]  flag_ff;
   logic [LINE_BITS-1:0] line_ff;
   trme_pkg::req_type ins_ff;
   logic [63:0] aval_ff;
   logic [1:0]  aerr_ff;
   logic        adest_ff, areg_ff;
   logic [AW-1:0] aslot_ff;
   logic [1:0]  aregn_ff;
   logic [63:0] bval, aval;
   logic [1:0]  berr;
   logic [1:0]  berr_ff;
   logic        ob_ff, ob_in;
   trme_pkg::rsp_type ob_data_ff;

   logic [63:0] rd_data, wr_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;

   trme_ram #(.WIDTH(64), .DEPTH(RD)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   function automatic logic [1:0] chk(input logic [1:0] kind, input logic [7:0] idx,
                                      input logic [63:0] regv [trme_pkg::NUM_REGS],
                                      output logic [AW-1:0] addr);
      logic [63:0] a;
      begin
         a = 64'd0;
         addr = '0;
         chk = trme_pkg::ERR_NONE;
         case (kind)
            trme_pkg::KIND_REG: if (idx >= 8'(trme_pkg::NUM_REGS)) chk = trme_pkg::ERR_OPERAND;
            trme_pkg::KIND_MEM: begin
               if ({56'd0, idx} >= 64'(MEM_WORDS)) chk = trme_pkg::ERR_RANGE;
               addr = AW'(idx);
            end
            trme_pkg::KIND_IND: begin
               a = regv[idx[1:0]];
               if (idx >= 8'(trme_pkg::NUM_REGS)) chk = trme_pkg::ERR_OPERAND;
               else if (a >= 64'(MEM_WORDS)) chk = trme_pkg::ERR_RANGE;
               addr = AW'(a);
            end
            default: chk = trme_pkg::ERR_NONE;
         endcase
      end
   endfunction

   logic [AW-1:0] addr_a, addr_b;
   logic [1:0] aerr_c, berr_c;
   logic [1:0] bregn_ff;
   logic [1:0] bkind_ff;
   logic start, fin;

   always_comb begin
      aerr_c = chk(q_data.first_kind, q_data.first_index, reg_ff, addr_a);
      berr_c = chk(ins_ff.second_kind, ins_ff.second_index, reg_ff, addr_b);
   end

   assign start = (st_ff == trme_pkg::ST_IDLE) && q_valid;
   assign fin = (st_ff == trme_pkg::ST_EXEC) && (!ob_ff || rsp.ready);

   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      case (st_ff)
         trme_pkg::ST_CLEAR: begin
            clr_in = clr_ff + (AW+1)'(1);
            if (clr_ff == (AW+1)'(RD - 1)) st_in = trme_pkg::ST_IDLE;
         end
         trme_pkg::ST_IDLE: if (q_valid) st_in = trme_pkg::ST_SECOND;
         trme_pkg::ST_SECOND: st_in = trme_pkg::ST_EXEC;
         trme_pkg::ST_EXEC: if (fin) st_in = trme_pkg::ST_IDLE;
         default: st_in = trme_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rd_addr = (st_ff == trme_pkg::ST_IDLE) ? addr_a : addr_b;
      q_pop = start;
   end

   // Execute stage.
   logic [1:0] err;
   logic [63:0] res;
   logic do_wr, cond, pv, setf;
   logic [1:0] newflag;
   logic [LINE_BITS-1:0] nl;
   logic [63:0] xa, xb;

   always_comb begin
      aval = aval_ff;
      bval = (bkind_ff == trme_pkg::KIND_MEM || bkind_ff == trme_pkg::KIND_IND)
             ? rd_data : ins_ff.second_immediate;
      if (bkind_ff == trme_pkg::KIND_REG) bval = reg_ff[bregn_ff];
      berr = berr_ff;
      err = trme_pkg::ERR_NONE;
      res = 64'd0;
      do_wr = 1'b0;
      cond = 1'b0;
      pv = 1'b0;
      setf = 1'b0;
      xa = aval ^ 64'h8000_0000_0000_0000;
      xb = bval ^ 64'h8000_0000_0000_0000;
      newflag = (xa > xb) ? trme_pkg::FLAG_GT : (xa < xb) ? trme_pkg::FLAG_LT
                                                          : trme_pkg::FLAG_EQ;
      case (trme_pkg::op_type'(ins_ff.op))
         trme_pkg::OP_ADD, trme_pkg::OP_SUB, trme_pkg::OP_AND, trme_pkg::OP_OR,
         trme_pkg::OP_MOV: begin
            if (aerr_ff != trme_pkg::ERR_NONE) err = aerr_ff;
            else if (!adest_ff) err = trme_pkg::ERR_OPERAND;
            else if (berr != trme_pkg::ERR_NONE) err = berr;
            else begin
               do_wr = 1'b1;
               case (trme_pkg::op_type'(ins_ff.op))
                  trme_pkg::OP_ADD: res = aval + bval;
                  trme_pkg::OP_SUB: res = aval - bval;
                  trme_pkg::OP_AND: res = aval & bval;
                  trme_pkg::OP_OR:  res = aval | bval;
                  default:          res = bval;
               endcase
            end
         end
         trme_pkg::OP_NOT, trme_pkg::OP_IN, trme_pkg::OP_OUT: begin
            if (aerr_ff != trme_pkg::ERR_NONE) err = aerr_ff;
            else if (!adest_ff) err = trme_pkg::ERR_OPERAND;
            else if (ins_ff.op == trme_pkg::OP_NOT) begin
               do_wr = 1'b1;
               res = ~aval;
            end else if (ins_ff.op == trme_pkg::OP_IN) begin
               do_wr = 1'b1;
               res = ins_ff.console_value;
            end else pv = 1'b1;
         end
         trme_pkg::OP_CMP: begin
            if (aerr_ff != trme_pkg::ERR_NONE) err = aerr_ff;
            else if (berr != trme_pkg::ERR_NONE) err = berr;
            else setf = 1'b1;
         end
         trme_pkg::OP_JMP: cond = 1'b1;
         trme_pkg::OP_JE:  cond = (flag_ff == trme_pkg::FLAG_EQ);
         trme_pkg::OP_JNE: cond = (flag_ff != trme_pkg::FLAG_EQ);
         trme_pkg::OP_JGE: cond = (flag_ff != trme_pkg::FLAG_LT);
         trme_pkg::OP_JL:  cond = (flag_ff == trme_pkg::FLAG_LT);
         trme_pkg::OP_NOP: cond = 1'b0;
         default: err = trme_pkg::ERR_OP;
      endcase
      if (err != trme_pkg::ERR_NONE) nl = line_ff;
      else if (cond) nl = LINE_BITS'({16'd0, ins_ff.jump_target});
      else nl = line_ff + LINE_BITS'(1);
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = aslot_ff;
      wr_data = res;
      if (st_ff == trme_pkg::ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = 64'd0;
      end else if (fin && do_wr && !areg_ff) begin
         wr_en = 1'b1;
      end
   end

   assign ob_in = fin || (ob_ff && !rsp.ready);
   assign rsp.valid = ob_ff;
   assign rsp.data = ob_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= trme_pkg::ST_CLEAR;
         clr_ff <= '0;
         ob_ff <= 1'b0;
         flag_ff <= trme_pkg::FLAG_EQ;
         line_ff <= '0;
         for (int i = 0; i < trme_pkg::NUM_REGS; i++) reg_ff[i] <= 64'd0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         ob_ff <= ob_in;
         if (fin) begin
            line_ff <= nl;
            if (setf) flag_ff <= newflag;
            if (do_wr && areg_ff) reg_ff[aregn_ff] <= res;
         end
      end
      if (start) begin
         ins_ff <= q_data;
         aerr_ff <= aerr_c;
         aslot_ff <= addr_a;
         aregn_ff <= q_data.first_index[1:0];
         areg_ff <= (q_data.first_kind == trme_pkg::KIND_REG);
         adest_ff <= (q_data.first_kind != trme_pkg::KIND_IMM);
         aval_ff <= (q_data.first_kind == trme_pkg::KIND_REG)
                    ? reg_ff[q_data.first_index[1:0]] : q_data.first_immediate;
      end
      if (st_ff == trme_pkg::ST_SECOND) begin
         berr_ff <= berr_c;
         bkind_ff <= ins_ff.second_kind;
         bregn_ff <= ins_ff.second_index[1:0];
         if (adest_ff && !areg_ff) aval_ff <= rd_data;
         adest_ff <= adest_ff;
      end
      if (fin) begin
         ob_data_ff.next_line <= 16'(nl);
         ob_data_ff.print_value <= pv ? aval : 64'd0;
         ob_data_ff.print_valid <= pv;
         ob_data_ff.jump_taken <= cond && (err == trme_pkg::ERR_NONE);
         ob_data_ff.compare_state <= setf ? newflag : flag_ff;
         ob_data_ff.error_code <= err;
      end
   end

`ifndef SYNTHESIS
   a_no_write_on_err: assert property (@(posedge clock) disable iff (reset)
      fin && err != trme_pkg::ERR_NONE |=> line_ff == $past(line_ff))
      else $error("line moved on error");
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      st_ff == trme_pkg::ST_CLEAR |-> !q_pop) else $error("item taken during clear");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      ob_ff && !rsp.ready |-> !fin) else $error("response overwritten");
`endif
endmodule

// ===== tb/tb_toy_register_memory_executor_unit.sv =====
// Self-checking testbench for the register/memory executor top level.
// Depends on trme_pkg, trme_if and the executor RTL; it predicts every result itself.
`timescale 1ns / 100ps

class trme_scoreboard;
   logic [63:0] regs [4];
   logic [63:0] mem [256];
   logic [1:0] flag;
   logic [15:0] line;
   trme_pkg::rsp_type pending[$];
   int errors;
   int checked;

   function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      flag = trme_pkg::FLAG_EQ;
      line = '0;
      errors = 0;
      checked = 0;
   endfunction

   function automatic void fetch(input logic [1:0] kind, input logic [7:0] idx,
                                 input logic [63:0] imm, output logic [1:0] err,
                                 output int dest, output logic [63:0] val);
      err = trme_pkg::ERR_NONE;
      dest = -1;
      val = '0;
      case (kind)
         trme_pkg::KIND_REG: begin
            if (idx >= 4) err = trme_pkg::ERR_OPERAND;
            else begin
               dest = idx;
               val = regs[idx];
            end
         end
         trme_pkg::KIND_MEM: begin
            dest = 4 + idx;
            val = mem[idx];
         end
         trme_pkg::KIND_IND: begin
            if (idx >= 4) err = trme_pkg::ERR_OPERAND;
            else if (regs[idx] >= 256) err = trme_pkg::ERR_RANGE;
            else begin
               dest = 4 + int'(regs[idx]);
               val = mem[regs[idx]];
            end
         end
         default: val = imm;
      endcase
   endfunction

   function automatic void store(input int dest, input logic [63:0] v);
      if (dest < 4) regs[dest] = v;
      else mem[dest - 4] = v;
   endfunction

   function void note_instruction(input trme_pkg::req_type r);
      logic [1:0] ea, eb, err;
      int da, db;
      logic [63:0] va, vb, res;
      logic cond;
      trme_pkg::rsp_type o;
      fetch(r.first_kind, r.first_index, r.first_immediate, ea, da, va);
      fetch(r.second_kind, r.second_index, r.second_immediate, eb, db, vb);
      err = trme_pkg::ERR_NONE;
      cond = 1'b0;
      o = '0;
      case (trme_pkg::op_type'(r.op))
         trme_pkg::OP_ADD, trme_pkg::OP_SUB, trme_pkg::OP_AND, trme_pkg::OP_OR,
         trme_pkg::OP_MOV: begin
            if (ea != trme_pkg::ERR_NONE) err = ea;
            else if (da < 0) err = trme_pkg::ERR_OPERAND;
            else if (eb != trme_pkg::ERR_NONE) err = eb;
            else begin
               case (trme_pkg::op_type'(r.op))
                  trme_pkg::OP_ADD: res = va + vb;
                  trme_pkg::OP_SUB: res = va - vb;
                  trme_pkg::OP_AND: res = va & vb;
                  trme_pkg::OP_OR: res = va | vb;
                  default: res = vb;
               endcase
               store(da, res);
            end
         end
         trme_pkg::OP_NOT, trme_pkg::OP_IN, trme_pkg::OP_OUT: begin
            if (ea != trme_pkg::ERR_NONE) err = ea;
            else if (da < 0) err = trme_pkg::ERR_OPERAND;
            else if (r.op == trme_pkg::OP_NOT) store(da, ~va);
            else if (r.op == trme_pkg::OP_IN) store(da, r.console_value);
            else begin
               o.print_value = va;
               o.print_valid = 1'b1;
            end
         end
         trme_pkg::OP_CMP: begin
            if (ea != trme_pkg::ERR_NONE) err = ea;
            else if (eb != trme_pkg::ERR_NONE) err = eb;
            else if ($signed(va) > $signed(vb)) flag = trme_pkg::FLAG_GT;
            else if ($signed(va) < $signed(vb)) flag = trme_pkg::FLAG_LT;
            else flag = trme_pkg::FLAG_EQ;
         end
         trme_pkg::OP_JMP: cond = 1'b1;
         trme_pkg::OP_JE: cond = (flag == trme_pkg::FLAG_EQ);
         trme_pkg::OP_JNE: cond = (flag != trme_pkg::FLAG_EQ);
         trme_pkg::OP_JGE: cond = (flag != trme_pkg::FLAG_LT);
         trme_pkg::OP_JL: cond = (flag == trme_pkg::FLAG_LT);
         trme_pkg::OP_NOP: ;
         default: err = trme_pkg::ERR_OP;
      endcase
      if (err != trme_pkg::ERR_NONE) begin
         o.print_value = '0;
         o.print_valid = 1'b0;
      end else if (cond) begin
         o.jump_taken = 1'b1;
         line = r.jump_target;
      end else begin
         line = line + 16'd1;
      end
      o.next_line = line;
      o.compare_state = flag;
      o.error_code = err;
      pending.insert(pending.size(), o);
   endfunction

   function void check_result(input trme_pkg::rsp_type got);
      trme_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $display("%0t: result with none outstanding, got %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      checked++;
      if (got.next_line !== want.next_line) begin
         $display("%0t: next_line expected %h got %h", $time, want.next_line, got.next_line);
         errors++;
      end
      if (got.print_value !== want.print_value) begin
         $display("%0t: print_value expected %h got %h", $time, want.print_value,
                  got.print_value);
         errors++;
      end
      if (got.print_valid !== want.print_valid) begin
         $display("%0t: print_valid expected %b got %b", $time, want.print_valid,
                  got.print_valid);
         errors++;
      end
      if (got.jump_taken !== want.jump_taken) begin
         $display("%0t: jump_taken expected %b got %b", $time, want.jump_taken,
                  got.jump_taken);
         errors++;
      end
      if (got.compare_state !== want.compare_state) begin
         $display("%0t: compare_state expected %b got %b", $time, want.compare_state,
                  got.compare_state);
         errors++;
      end
      if (got.error_code !== want.error_code) begin
         $display("%0t: error_code expected %0d got %0d", $time, want.error_code,
                  got.error_code);
         errors++;
      end
   endfunction
endclass

module tb_toy_register_memory_executor_unit;
   logic clock = 1'b0;
   logic reset = 1'b1;
   trme_req_if req ();
   trme_rsp_if rsp ();
   trme_scoreboard machine = new();
   int idle_cycles = 0;
   int sent = 0;
   bit hold_off = 1'b0;
   bit tail_stall = 1'b0;

   toy_register_memory_executor_unit u_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #1 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return '1;
         3: return 64'(($urandom_range(0, 300)));
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [7:0] rand_index(input logic [1:0] kind);
      if (kind != trme_pkg::KIND_MEM && $urandom_range(0, 9) < 8)
         return 8'($urandom_range(0, 3));
      return 8'($urandom());
   endfunction

   function automatic trme_pkg::req_type random_instruction();
      trme_pkg::req_type r;
      r.op = ($urandom_range(0, 49) == 0) ? trme_pkg::OP_BAD : 4'($urandom_range(0, 14));
      r.first_kind = ($urandom_range(0, 9) < 1) ? trme_pkg::KIND_IMM
                                                 : 2'($urandom_range(0, 2));
      r.first_index = rand_index(r.first_kind);
      r.first_immediate = rand_word();
      r.second_kind = 2'($urandom_range(0, 3));
      r.second_index = rand_index(r.second_kind);
      r.second_immediate = rand_word();
      r.jump_target = 16'($urandom());
      r.console_value = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 255))
                                                   : rand_word();
      return r;
   endfunction

   function automatic trme_pkg::req_type make_instruction(
         input trme_pkg::op_type op, input trme_pkg::kind_type k1,
         input logic [7:0] i1, input logic [63:0] m1,
         input trme_pkg::kind_type k2, input logic [7:0] i2,
         input logic [63:0] m2);
      trme_pkg::req_type r;
      r = random_instruction();
      r.op = op;
      r.first_kind = k1;
      r.first_index = i1;
      r.first_immediate = m1;
      r.second_kind = k2;
      r.second_index = i2;
      r.second_immediate = m2;
      return r;
   endfunction

   task automatic send_instruction(input trme_pkg::req_type r, input bit with_gaps);
      int g;
      g = with_gaps ? gap_length() : 0;
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      machine.note_instruction(r);
      sent++;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (machine.pending.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) machine.check_result(rsp.data);
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("toy_register_memory_executor_unit verification failed");
         $finish;
      end
   end

   initial begin : receiver
      int g;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp.ready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
         g = tail_stall ? 0 : gap_length();
         if (g > 0) begin
            rsp.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_instruction(make_instruction(trme_pkg::OP_MOV, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_IMM, 0, 64'h7fff_ffff_ffff_ffff), 0);
      send_instruction(make_instruction(trme_pkg::OP_ADD, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_IMM, 0, 64'd1), 0);
      send_instruction(make_instruction(trme_pkg::OP_MOV, trme_pkg::KIND_REG, 1, 0,
                                        trme_pkg::KIND_IMM, 0, 64'd255), 0);
      send_instruction(make_instruction(trme_pkg::OP_MOV, trme_pkg::KIND_IND, 1, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_OUT, trme_pkg::KIND_MEM, 255, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_SUB, trme_pkg::KIND_MEM, 7, 0,
                                        trme_pkg::KIND_IMM, 0, 64'd3), 0);
      send_instruction(make_instruction(trme_pkg::OP_AND, trme_pkg::KIND_REG, 3, 0,
                                        trme_pkg::KIND_MEM, 7, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_OR, trme_pkg::KIND_REG, 2, 0,
                                        trme_pkg::KIND_IND, 1, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_NOT, trme_pkg::KIND_REG, 2, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_IN, trme_pkg::KIND_MEM, 0, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_OUT, trme_pkg::KIND_REG, 3, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_CMP, trme_pkg::KIND_IMM, 0,
                                        64'h8000_0000_0000_0000, trme_pkg::KIND_IMM, 0,
                                        64'h7fff_ffff_ffff_ffff), 0);
      send_instruction(make_instruction(trme_pkg::OP_JL, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_JNE, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_JE, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_CMP, trme_pkg::KIND_REG, 1, 0,
                                        trme_pkg::KIND_IMM, 0, 64'd255), 0);
      send_instruction(make_instruction(trme_pkg::OP_JGE, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_JMP, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_NOP, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_BAD, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_MOV, trme_pkg::KIND_REG, 200, 0,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_MOV, trme_pkg::KIND_IMM, 0, 5,
                                        trme_pkg::KIND_REG, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_MOV, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_IND, 0, 0), 0);
      send_instruction(make_instruction(trme_pkg::OP_CMP, trme_pkg::KIND_REG, 0, 0,
                                        trme_pkg::KIND_REG, 9, 0), 0);
      wait_drained();
      hold_off = 1'b1;
      repeat (12) send_instruction(random_instruction(), 0);
      for (int n = 0; n < 1620; n++) begin
         send_instruction(random_instruction(), (n % 200) >= 40);
         if (n == 800) wait_drained();
      end
      wait_drained();
      tail_stall = 1'b1;
      repeat (20) @(posedge clock);
      $display("Sent %0d instructions, checked %0d results, covering every op, operand",
               sent, machine.checked);
      $display("kind, error case and a long receiver stall with the input queue full.");
      if (machine.errors == 0 && machine.pending.size() == 0)
         $display("toy_register_memory_executor_unit verification clean");
      else
         $display("toy_register_memory_executor_unit verification failed");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/trme_pkg.sv
rtl/trme_if.sv
rtl/trme_ram.sv
rtl/trme_front.sv
rtl/trme_back.sv
rtl/toy_register_memory_executor_unit.sv
tb/tb_toy_register_memory_executor_unit.sv
